// ===== rtl/pswc_pkg.sv =====
// Package for the PID step block: shared types, codes and widths.
`default_nettype none

package pswc_pkg;

   localparam int DATA_W   = 32;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INC,
      ST_DER,
      ST_PROP,
      ST_INTEG,
      ST_DERIV,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_INC,
      MUL_DER,
      MUL_PROP,
      MUL_INTEG,
      MUL_DERIV
   } mul_sel_type;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4,
      CSR_SAMPLE_PERIOD  = 3'd5,
      CSR_SAMPLE_RATE    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        integ_upd;
      logic        deriv_upd;
      logic        acc_load;
      logic        acc_add;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/pswc_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface pswc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] error_sample;

   modport source (output valid, output error_sample, input ready);
   modport sink   (input valid, input error_sample, output ready);
endinterface

interface pswc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_value;

   modport source (output valid, output drive_value, input ready);
   modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/pswc_ctrl.sv =====
// Sequencer for the PID step: walks the shared multiplier through its five products.
`default_nettype none

module pswc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pswc_pkg::status_type status,
   output pswc_pkg::cmd_type    cmd
);
   import pswc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_INC;
            end
         end
         ST_INC: begin
            cmd.mul_sel = MUL_INC;
            state_in    = ST_DER;
         end
         ST_DER: begin
            cmd.mul_sel   = MUL_DER;
            cmd.integ_upd = 1'b1;
            state_in      = ST_PROP;
         end
         ST_PROP: begin
            cmd.mul_sel   = MUL_PROP;
            cmd.deriv_upd = 1'b1;
            state_in      = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.mul_sel  = MUL_INTEG;
            cmd.acc_load = 1'b1;
            state_in     = ST_DERIV;
         end
         ST_DERIV: begin
            cmd.mul_sel = MUL_DERIV;
            cmd.acc_add = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/pswc_dp.sv =====
// Datapath for the PID step: registers, shared multiplier, rounding, saturation.
`default_nettype none

module pswc_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pswc_pkg::cmd_type                     cmd,
   output pswc_pkg::status_type                  status,
   input  logic                                  csr_we,
   input  logic [pswc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pswc_pkg::DATA_W-1:0]           csr_wdata,
   input  logic signed [pswc_pkg::DATA_W-1:0]    error_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pswc_pkg::DATA_W-1:0]    drive_value
);
   import pswc_pkg::*;

   localparam logic signed [65:0] SAT_HI  = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO  = -66'sd2147483648;
   localparam logic signed [65:0] HALF_16 = 66'sd32768;
   localparam logic signed [65:0] HALF_24 = 66'sd8388608;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7fff_ffff;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // zero limit leaves the value alone
   function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                    input logic [30:0] lim);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      logic signed [31:0] r;
      hi = signed'({1'b0, lim});
      lo = -hi;
      r  = v;
      if (lim != '0) begin
         if (v > hi) begin
            r = hi;
         end else if (v < lo) begin
            r = lo;
         end
      end
      return r;
   endfunction

   // configuration
   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [30:0]        ilim_ff, olim_ff;
   logic [23:0]        period_ff;
   logic [15:0]        rate_ff;

   // working registers
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [31:0] deriv_ff, deriv_in;
   logic signed [33:0] acc_ff, acc_in;
   logic signed [65:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] drive_ff, drive_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] inc_wide;
   logic signed [65:0] integ_sum;
   logic signed [31:0] term;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         ilim_ff   <= '0;
         olim_ff   <= '0;
         period_ff <= 24'd67109;
         rate_ff   <= 16'd250;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:      kp_ff     <= csr_wdata;
            CSR_INTEG_GAIN:     ki_ff     <= csr_wdata;
            CSR_DERIV_GAIN:     kd_ff     <= csr_wdata;
            CSR_INTEGRAL_LIMIT: ilim_ff   <= csr_wdata[30:0];
            CSR_OUTPUT_LIMIT:   olim_ff   <= csr_wdata[30:0];
            CSR_SAMPLE_PERIOD:  period_ff <= csr_wdata[23:0];
            CSR_SAMPLE_RATE:    rate_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared 33x33 multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_INC: begin
            mul_a = 33'(err_ff);
            mul_b = signed'({9'd0, period_ff});
         end
         MUL_DER: begin
            mul_a = 33'(err_ff) - 33'(last_err_ff);
            mul_b = signed'({17'd0, rate_ff});
         end
         MUL_PROP: begin
            mul_a = 33'(kp_ff);
            mul_b = 33'(err_ff);
         end
         MUL_INTEG: begin
            mul_a = 33'(ki_ff);
            mul_b = 33'(integ_ff);
         end
         MUL_DERIV: begin
            mul_a = 33'(kd_ff);
            mul_b = 33'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 66'(mul_a) * 66'(mul_b);

   assign inc_wide  = (prod_ff + HALF_24) >>> 24;
   assign integ_sum = 66'(integ_ff) + inc_wide;
   assign term      = sat32((prod_ff + HALF_16) >>> 16);

   always_comb begin
      err_in       = cmd.capture   ? error_sample : err_ff;
      integ_in     = cmd.integ_upd ? clamp_mag(sat32(integ_sum), ilim_ff) : integ_ff;
      deriv_in     = cmd.deriv_upd ? sat32(prod_ff) : deriv_ff;
      acc_in       = acc_ff;
      if (cmd.acc_load) begin
         acc_in = 34'(term);
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + 34'(term);
      end
      last_err_in  = cmd.finish ? err_ff : last_err_ff;
      drive_in     = cmd.finish ? clamp_mag(sat32(66'(acc_ff)), olim_ff) : drive_ff;
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      deriv_ff <= deriv_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      drive_ff <= drive_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign drive_value     = drive_ff;

endmodule

`default_nettype wire

// ===== rtl/pid_step_with_clamps.sv =====
// Top level of the one-channel PID step with integral and output clamps.
// An error beat is taken only in ST_IDLE; one multiplier is shared by the five
//   products (increment, derivative, P, I, D), one product per cycle, in INC to
//   DERIV; ACC and OUT follow, and the drive beat is registered as OUT ends.
// A finished drive beat waits in its output register; the next error beat is
//   taken meanwhile, and the sequencer holds only if the register is still full.
// Reset (synchronous): gains and limits zero, period 67109, rate 250,
//   integral and last error zero, no beat pending.
`default_nettype none

module pid_step_with_clamps (
   input  logic                           clock,
   input  logic                           reset,
   pswc_req_if.sink                       req_if,
   pswc_rsp_if.source                     rsp_if,
   input  logic                           csr_we,
   input  logic [pswc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pswc_pkg::DATA_W-1:0]    csr_wdata
);
   import pswc_pkg::*;

   cmd_type    cmd;     // sequencer to datapath
   status_type status;  // datapath to sequencer
   logic       req_ready;
   logic       rsp_valid;
   logic signed [DATA_W-1:0] drive_value;

   // Sequencer: idle until a request beat, then one step per product,
   // rounding and accumulation using each product in the cycle after the multiplier.
   pswc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: register file, shared multiplier, saturation and clamps.
   pswc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_sample (req_if.error_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_if.ready),
      .drive_value  (drive_value)
   );

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.drive_value = drive_value;

endmodule

`default_nettype wire
